>>> rtl/itaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package itaf_pkg;

  localparam logic [2:0] ACT_SDEC = 3'd0;
  localparam logic [2:0] ACT_UDEC = 3'd1;
  localparam logic [2:0] ACT_HEXL = 3'd2;
  localparam logic [2:0] ACT_HEXU = 3'd3;
  localparam logic [2:0] ACT_PTR  = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam int unsigned DecDigits = 10;
  localparam int unsigned BinBits   = 32;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_HEX
  } prefix_e;

  typedef struct packed {
    logic        dec;
    logic        wide;
    logic        upper;
    prefix_e     prefix;
    logic [63:0] mag;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_SKIP,
    BK_PRE,
    BK_DIG
  } back_state_e;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'd0, nib};
    end else if (upper) begin
      ch = 8'h41 + {4'd0, nib - 4'd10};
    end else begin
      ch = 8'h61 + {4'd0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> rtl/itaf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module itaf_front (
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [2:0]      action_i,
  input  wire logic [63:0]     value_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output itaf_pkg::entry_t     entry_o
);
  import itaf_pkg::*;

  logic        known;
  logic [31:0] low;

  assign low        = value_i[31:0];
  assign in_stall_o = full_i;

  always_comb begin
    known   = 1'b1;
    entry_o = '{dec: 1'b0, wide: 1'b0, upper: 1'b0, prefix: PFX_NONE,
                mag: {32'd0, low}};
    case (action_i)
      ACT_SDEC: begin
        entry_o.dec = 1'b1;
        if (low[31]) begin
          entry_o.prefix = PFX_MINUS;
          entry_o.mag    = {32'd0, ~low + 32'd1};
        end
      end
      ACT_UDEC: entry_o.dec = 1'b1;
      ACT_HEXL: entry_o.dec = 1'b0;
      ACT_HEXU: entry_o.upper = 1'b1;
      ACT_PTR: begin
        entry_o.wide   = 1'b1;
        entry_o.prefix = PFX_HEX;
        entry_o.mag    = value_i;
      end
      default: known = 1'b0;
    endcase
  end

  // unknown actions are taken and dropped
  assign push_o = in_valid_i && !full_i && known;

endmodule
`default_nettype wire

>>> rtl/itaf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module itaf_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire itaf_pkg::entry_t wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output itaf_pkg::entry_t      rdata_o
);
  import itaf_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == CW'(Depth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/itaf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module itaf_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire itaf_pkg::entry_t entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            character_o,
  output logic                  last_o,
  output logic [31:0]           running_total_o
);
  import itaf_pkg::*;

  back_state_e state_q, state_d;
  logic [63:0] digits_q, digits_d;
  logic [31:0] bin_q, bin_d;
  logic [4:0]  ndig_q, ndig_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        upper_q, upper_d;
  prefix_e     prefix_q, prefix_d;
  logic        pre_idx_q, pre_idx_d;

  logic        out_valid_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic [31:0] total_q;

  logic        out_free;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;
  logic [39:0] bcd_adj;

  assign out_free = !out_valid_q || !out_stall_i;

  // add-3 correction on each bcd digit
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      bcd_adj[4*i +: 4] = (digits_q[24 + 4*i +: 4] >= 4'd5) ?
                          digits_q[24 + 4*i +: 4] + 4'd3 : digits_q[24 + 4*i +: 4];
    end
  end

  always_comb begin
    state_d   = state_q;
    digits_d  = digits_q;
    bin_d     = bin_q;
    ndig_d    = ndig_q;
    cnt_d     = cnt_q;
    upper_d   = upper_q;
    prefix_d  = prefix_q;
    pre_idx_d = pre_idx_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_char = CH_ZERO;
    emit_last = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          upper_d   = entry_i.upper;
          prefix_d  = entry_i.prefix;
          pre_idx_d = 1'b0;
          cnt_d     = '0;
          if (entry_i.dec) begin
            bin_d    = entry_i.mag[31:0];
            digits_d = '0;
            ndig_d   = 5'(DecDigits);
            state_d  = BK_CONV;
          end else if (entry_i.wide) begin
            digits_d = entry_i.mag;
            ndig_d   = 5'd16;
            state_d  = BK_SKIP;
          end else begin
            digits_d = {entry_i.mag[31:0], 32'd0};
            ndig_d   = 5'd8;
            state_d  = BK_SKIP;
          end
        end
      end
      BK_CONV: begin
        digits_d[63:24] = {bcd_adj[38:0], bin_q[31]};
        bin_d           = {bin_q[30:0], 1'b0};
        cnt_d           = cnt_q + 5'd1;
        if (cnt_q == 5'(BinBits - 1)) begin
          state_d = BK_SKIP;
        end
      end
      BK_SKIP: begin
        if (digits_q[63:60] == 4'd0 && ndig_q > 5'd1) begin
          digits_d = {digits_q[59:0], 4'd0};
          ndig_d   = ndig_q - 5'd1;
        end else if (prefix_q != PFX_NONE) begin
          state_d = BK_PRE;
        end else begin
          state_d = BK_DIG;
        end
      end
      BK_PRE: begin
        if (out_free) begin
          emit = 1'b1;
          if (prefix_q == PFX_MINUS) begin
            emit_char = CH_MINUS;
            state_d   = BK_DIG;
          end else if (!pre_idx_q) begin
            emit_char = CH_ZERO;
            pre_idx_d = 1'b1;
          end else begin
            emit_char = CH_X;
            state_d   = BK_DIG;
          end
        end
      end
      BK_DIG: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = digit_char(digits_q[63:60], upper_q);
          emit_last = ndig_q == 5'd1;
          digits_d  = {digits_q[59:0], 4'd0};
          ndig_d    = ndig_q - 5'd1;
          if (ndig_q == 5'd1) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      ndig_q      <= '0;
      cnt_q       <= '0;
      pre_idx_q   <= 1'b0;
      prefix_q    <= PFX_NONE;
    end else begin
      state_q   <= state_d;
      ndig_q    <= ndig_d;
      cnt_q     <= cnt_d;
      pre_idx_q <= pre_idx_d;
      prefix_q  <= prefix_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        total_q     <= total_q + 32'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    bin_q    <= bin_d;
    upper_q  <= upper_d;
    if (emit) begin
      char_q <= emit_char;
      last_q <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign character_o     = char_q;
  assign last_o          = last_q;
  assign running_total_o = total_q;

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> total_q == $past(total_q) + 32'd1)
    else $error("running total did not step with an emitted item");

  a_dig_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIG || state_q == BK_SKIP) |-> ndig_q != 5'd0)
    else $error("digit count empty while digits remain to send");

  a_conv_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CONV && cnt_q == 5'(BinBits - 1)) |=> state_q == BK_SKIP)
    else $error("conversion did not finish after all bits");

  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> state_q == BK_IDLE)
    else $error("last item sent but back end not idle");

endmodule
`default_nettype wire

>>> rtl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake                     | payload
// ---------+-------------------------------+-------------------------------------
// input    | in_valid_i / in_stall_o       | action_i[2:0], value_i[63:0]
// output   | out_valid_o / out_stall_i     | character_o[7:0], last_o,
//          |                               | running_total_o[31:0]
//
// decimal items: a load, a conversion step per input bit (one bit per cycle double-dabble
// in the back end), a zero-skip step, then the characters one by one
// hex and pointer items: a load, a zero-skip step, then the characters one by one
// a small queue lets the input take further items while the back end works
// reset clears the queue, the back end state and the running total
// an output stall holds the current character; the back end pauses only where it has a character to send
module integer_to_ascii_formatter #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       character_o,
  output logic             last_o,
  output logic [31:0]      running_total_o
);
  import itaf_pkg::*;

  entry_t push_entry, pop_entry;
  logic   push, pop, full, empty;

  itaf_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .value_i    (value_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  itaf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (pop_entry)
  );

  itaf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .entry_i         (pop_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .character_o     (character_o),
    .last_o          (last_o),
    .running_total_o (running_total_o)
  );

endmodule
`default_nettype wire

>>> bench/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 1ps
module integer_to_ascii_formatter_tb;
  import itaf_pkg::*;

  localparam logic [2:0] ACT_RSV5 = 3'd5;
  localparam logic [2:0] ACT_RSV6 = 3'd6;
  localparam logic [2:0] ACT_RSV7 = 3'd7;

  localparam int RandomPerPhase = 100;
  localparam int HoldCycles     = 400;
  localparam int QuietLimit     = 5000;
  localparam int DrainCycles    = 100;
  localparam int NumDirected    = 23;

  typedef byte unsigned text_t[$];

  typedef struct packed {
    logic [7:0]  character;
    logic        last;
    logic [31:0] total;
  } char_rec_t;

  typedef struct {
    logic [2:0]  action;
    logic [63:0] value;
    bit          fixed;
    string       text;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i = ACT_SDEC;
  logic [63:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  character_o;
  logic        last_o;
  logic [31:0] running_total_o;

  char_rec_t   pending_chars[$];
  logic [31:0] chars_so_far = '0;
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          pressure_on = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  dir_row_t directed [NumDirected] = '{
    '{ACT_SDEC, 64'd0,                   1'b1, "0"},
    '{ACT_SDEC, 64'h0000_0000_8000_0000, 1'b1, "-2147483648"},
    '{ACT_SDEC, 64'h0000_0000_7fff_ffff, 1'b1, "2147483647"},
    '{ACT_SDEC, 64'h0000_0000_ffff_ffff, 1'b1, "-1"},
    '{ACT_SDEC, 64'hffff_ffff_0000_0005, 1'b1, "5"},
    '{ACT_SDEC, 64'hffff_ffff_ffff_ff9c, 1'b1, "-100"},
    '{ACT_SDEC, 64'h0000_0000_8000_0001, 1'b0, ""},
    '{ACT_UDEC, 64'd0,                   1'b1, "0"},
    '{ACT_UDEC, 64'h0000_0000_ffff_ffff, 1'b1, "4294967295"},
    '{ACT_UDEC, 64'h1234_5678_8000_0000, 1'b1, "2147483648"},
    '{ACT_UDEC, 64'd1234567890,          1'b0, ""},
    '{ACT_HEXL, 64'd0,                   1'b1, "0"},
    '{ACT_HEXL, 64'h0000_0000_ffff_ffff, 1'b1, "ffffffff"},
    '{ACT_HEXL, 64'h0000_0001_dead_beef, 1'b0, ""},
    '{ACT_HEXU, 64'h0000_0000_ffff_ffff, 1'b1, "FFFFFFFF"},
    '{ACT_HEXU, 64'hffff_ffff_0a1b_2c3d, 1'b0, ""},
    '{ACT_PTR,  64'd0,                   1'b1, "0x0"},
    '{ACT_PTR,  64'hffff_ffff_ffff_ffff, 1'b1, "0xffffffffffffffff"},
    '{ACT_PTR,  64'h8000_0000_0000_0000, 1'b1, "0x8000000000000000"},
    '{ACT_PTR,  64'h0000_7ffd_1234_abcd, 1'b0, ""},
    '{ACT_RSV5, 64'hffff_ffff_ffff_ffff, 1'b1, ""},
    '{ACT_RSV6, 64'd0,                   1'b1, ""},
    '{ACT_RSV7, 64'h0000_0000_8000_0000, 1'b1, ""}
  };

  integer_to_ascii_formatter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .character_o    (character_o),
    .last_o         (last_o),
    .running_total_o(running_total_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic text_t format_text(input logic [2:0] act, input logic [63:0] val);
    text_t       txt;
    logic [63:0] mag;
    logic [63:0] base;
    logic [31:0] low;
    string       digit_set;
    bit          known;
    int          pos;
    low = val[31:0];
    mag = {32'd0, low};
    base = 64'd10;
    digit_set = "0123456789abcdef";
    known = 1'b1;
    case (act)
      ACT_SDEC: begin
        if (low[31]) begin
          txt.push_back(CH_MINUS);
          mag = {32'd0, -low};
        end
      end
      ACT_UDEC: ;
      ACT_HEXL: base = 64'd16;
      ACT_HEXU: begin
        base = 64'd16;
        digit_set = "0123456789ABCDEF";
      end
      ACT_PTR: begin
        base = 64'd16;
        mag = val;
        txt.push_back(CH_ZERO);
        txt.push_back(CH_X);
      end
      default: known = 1'b0;
    endcase
    if (known) begin
      if (mag == 64'd0) begin
        txt.push_back(CH_ZERO);
      end else begin
        pos = txt.size();
        while (mag != 64'd0) begin
          txt.insert(pos, digit_set[int'(mag % base)]);
          mag = mag / base;
        end
      end
    end
    return txt;
  endfunction

  function automatic text_t spell(input string s);
    text_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    return txt;
  endfunction

  function automatic void queue_text(input text_t txt);
    char_rec_t rec;
    foreach (txt[i]) begin
      chars_so_far = chars_so_far + 32'd1;
      rec.character = txt[i];
      rec.last = (i == txt.size() - 1);
      rec.total = chars_so_far;
      pending_chars.push_back(rec);
    end
  endfunction

  function automatic logic [2:0] pick_action();
    if ($urandom_range(99) < 5) return 3'($urandom_range(ACT_RSV7, ACT_RSV5));
    return 3'($urandom_range(ACT_PTR));
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v = '0;
      1: v[31:0] = 32'h8000_0000;
      2: v = '1;
      3, 4, 5: v = v >> $urandom_range(63);
      6: v[31:0] = v[31:0] >> $urandom_range(31);
      default: ;
    endcase
    return v;
  endfunction

  task automatic offer(input logic [2:0] act, input logic [63:0] val, input text_t txt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    queue_text(txt);
    @(negedge clk_i);
  endtask

  // receiver: random stalls plus one long hold-off while the sender keeps going
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_on && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_out
    char_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected item, expected none, got char %h last %b total %0d",
                 $time, character_o, last_o, running_total_o);
        err_count++;
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.character) begin
          $display("%0t: character expected %h got %h", $time, want.character, character_o);
          err_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, last_o);
          err_count++;
        end
        if (running_total_o !== want.total) begin
          $display("%0t: running_total expected %0d got %0d", $time, want.total,
                   running_total_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          n;
    logic [2:0]  act;
    logic [63:0] val;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      offer(directed[i].action, directed[i].value,
            directed[i].fixed ? spell(directed[i].text) :
                                format_text(directed[i].action, directed[i].value));
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
          pressure_on <= 1'b1;
        end
        1: begin
          send_idle_pct = 55;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 55;
        end
        default: begin
          send_idle_pct = 14;
          stall_pct <= 14;
        end
      endcase
      n = 0;
      while (n < RandomPerPhase) begin
        act = pick_action();
        val = pick_value();
        if (act <= ACT_PTR) n++;
        offer(act, val, format_text(act, val));
      end
    end
    in_valid_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && pending_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/itaf_pkg.sv
rtl/itaf_front.sv
rtl/itaf_fifo.sv
rtl/itaf_back.sv
rtl/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_tb.sv
